>>> rtl/hvs_pkg.sv
// shared widths, codes and types of the heightmap vertex selector
`default_nettype none

package hvs_pkg;

  // default number of cells in the row chain
  localparam int DEF_MAX_WIDTH = 32;

  // payload and register widths
  localparam int SAMPLE_W     = 8;
  localparam int GRID_WIDTH_W = 6;
  localparam int ROW_W        = 12;
  localparam int ORIGIN_W     = 15;
  localparam int YBASE_W      = 18;
  localparam int EDGE_THR_W   = 9;
  localparam int INNER_THR_W  = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 18;
  localparam int VX_W         = 16;
  localparam int VY_W         = 19;
  localparam int VZ_W         = 16;
  localparam int COLUMN_W     = 5;

  // register reset values
  localparam logic [GRID_WIDTH_W-1:0] RST_GRID_WIDTH  = GRID_WIDTH_W'(32);
  localparam logic [ROW_W-1:0]        RST_GRID_HEIGHT = ROW_W'(32);
  localparam logic [YBASE_W-1:0]      RST_Y_BASE      = YBASE_W'(4);
  localparam logic [INNER_THR_W-1:0]  RST_INNER_THR   = INNER_THR_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_X_ORIGIN    = 3'd2,
    CFG_Z_ORIGIN    = 3'd3,
    CFG_Y_BASE      = 3'd4,
    CFG_EDGE_THR    = 3'd5,
    CFG_INNER_THR   = 3'd6
  } hvs_cfg_idx_t;

  // which keep test applies to a grid point
  typedef enum logic [1:0] {
    MODE_CORNER = 2'd0,
    MODE_VEDGE  = 2'd1,
    MODE_HEDGE  = 2'd2,
    MODE_INNER  = 2'd3
  } hvs_mode_t;

  // control handed to every cell of the row chain
  typedef struct packed {
    logic                shift;
    logic                rotate;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] head;
  } hvs_chain_ctl_t;

  // one grid point waiting for its keep decision
  typedef struct packed {
    hvs_mode_t           mode;
    logic [SAMPLE_W-1:0] ct;
    logic [SAMPLE_W-1:0] lf;
    logic [SAMPLE_W-1:0] rt;
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] dn;
    logic                last;
  } hvs_cand_t;

endpackage

`default_nettype wire

>>> rtl/hvs_if.sv
// valid/ready channel interfaces for samples and kept vertices
`default_nettype none

interface hvs_in_if import hvs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

interface hvs_out_if import hvs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VX_W-1:0]     vertex_x;
  logic signed [VY_W-1:0]     vertex_y_quarters;
  logic signed [VZ_W-1:0]     vertex_z;
  logic        [COLUMN_W-1:0] column;
  logic        [ROW_W-1:0]    row;
  logic                       last_of_run;

  modport source (output valid, output vertex_x, output vertex_y_quarters, output vertex_z,
                  output column, output row, output last_of_run, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y_quarters, input vertex_z,
                  input column, input row, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/hvs_cell.sv
// one cell of the row chain: a prior-row and an older-row sample
`default_nettype none

module hvs_cell import hvs_pkg::*; (
  input  logic                clk,
  input  hvs_chain_ctl_t      ctl,
  input  logic                insert,
  input  logic [SAMPLE_W-1:0] prior_right,
  input  logic [SAMPLE_W-1:0] older_right,
  output logic [SAMPLE_W-1:0] prior_q,
  output logic [SAMPLE_W-1:0] older_q
);

  logic [SAMPLE_W-1:0] prior_r, prior_nxt;
  logic [SAMPLE_W-1:0] older_r, older_nxt;

  always_comb begin
    prior_nxt = prior_r;
    older_nxt = older_r;
    if (ctl.shift) begin
      // the insert cell takes the new sample, the leaving head drops into the older row
      prior_nxt = insert ? ctl.sample : prior_right;
      older_nxt = insert ? ctl.head : older_right;
    end else if (ctl.rotate) begin
      prior_nxt = insert ? ctl.head : prior_right;
    end
  end

  always_ff @(posedge clk) begin
    prior_r <= prior_nxt;
    older_r <= older_nxt;
  end

  assign prior_q = prior_r;
  assign older_q = older_r;

endmodule

`default_nettype wire

>>> rtl/hvs_decide.sv
// keep test for one grid point: corner, border difference or curvature
`default_nettype none

module hvs_decide import hvs_pkg::*; (
  input  hvs_cand_t              cand,
  input  logic [EDGE_THR_W-1:0]  edge_thr,
  input  logic [INNER_THR_W-1:0] inner_thr,
  output logic                   keep
);

  localparam int SUM_W = 11;

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] n;
    n = -v;
    mag = v[SUM_W-1] ? n : v;
  endfunction

  logic signed [SUM_W-1:0] ct_s, lf_s, rt_s, up_s, dn_s;
  logic [SUM_W-1:0] sum_v, sum_h, sum_i;

  assign ct_s = $signed({3'b000, cand.ct});
  assign lf_s = $signed({3'b000, cand.lf});
  assign rt_s = $signed({3'b000, cand.rt});
  assign up_s = $signed({3'b000, cand.up});
  assign dn_s = $signed({3'b000, cand.dn});

  assign sum_v = mag(up_s - ct_s) + mag(dn_s - ct_s);
  assign sum_h = mag(lf_s - ct_s) + mag(rt_s - ct_s);
  assign sum_i = mag(up_s + dn_s - (ct_s <<< 1)) + mag(lf_s + rt_s - (ct_s <<< 1));

  always_comb begin
    unique case (cand.mode)
      MODE_CORNER: keep = 1'b1;
      MODE_VEDGE:  keep = sum_v > SUM_W'(edge_thr);
      MODE_HEDGE:  keep = sum_h > SUM_W'(edge_thr);
      MODE_INNER:  keep = sum_i > SUM_W'(inner_thr);
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/heightmap_vertex_selector_top.sv
// top level of the heightmap vertex selector
`default_nettype none

// Heightmap bytes come in raster order on in_ch, one per transfer, and the grid
// points kept as mesh vertices leave in raster order on out_ch. A point of row r is
// decided when the sample in its column of row r+1 arrives; the decision is made in
// a candidate register in the cycle after the transfer, and a kept vertex is then
// presented from the output register. Samples are taken at one per cycle while
// out_ch keeps up. The last sample of a frame starts a flush of the last row, which
// rotates the prior-row chain once through the cells, one column a cycle while out_ch
// keeps up; the input is held off during it, and that transfer may cause up to one
// more vertex than the clamped width, the last one carrying last_of_run. Write the
// registers only while the block is idle; writing grid_width or grid_height starts a
// new frame. Row storage is a chain of MAX_WIDTH cells, so MAX_WIDTH bounds grid_width.
module heightmap_vertex_selector_top import hvs_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hvs_in_if.sink                in_ch,
  hvs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

  // configuration registers
  logic [GRID_WIDTH_W-1:0]   grid_width_r, grid_width_nxt;
  logic [ROW_W-1:0]          grid_height_r, grid_height_nxt;
  logic [ORIGIN_W-1:0]       x_origin_r, x_origin_nxt;
  logic [ORIGIN_W-1:0]       z_origin_r, z_origin_nxt;
  logic [YBASE_W-1:0]        y_base_r, y_base_nxt;
  logic [EDGE_THR_W-1:0]     edge_thr_r, edge_thr_nxt;
  logic [INNER_THR_W-1:0]    inner_thr_r, inner_thr_nxt;

  // position and flush control
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic                      flush_r, flush_nxt;
  logic [COL_W-1:0]          fl_col_r, fl_col_nxt;
  logic [SAMPLE_W-1:0]       lf_r, lf_nxt;

  // candidate stage
  logic                      cand_valid_r, cand_valid_nxt;
  hvs_cand_t                 cand_r, cand_nxt;
  logic [COL_W-1:0]          cand_col_r, cand_col_nxt;
  logic [ROW_W-1:0]          cand_row_r, cand_row_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VX_W-1:0]    out_x_r, out_x_nxt;
  logic signed [VY_W-1:0]    out_y_r, out_y_nxt;
  logic signed [VZ_W-1:0]    out_z_r, out_z_nxt;
  logic [COLUMN_W-1:0]       out_col_r, out_col_nxt;
  logic [ROW_W-1:0]          out_row_r, out_row_nxt;
  logic                      out_last_r, out_last_nxt;

  // row chain taps
  logic [SAMPLE_W-1:0]       prior_q [MAX_WIDTH];
  logic [SAMPLE_W-1:0]       older_q [MAX_WIDTH];
  logic [MAX_WIDTH-1:0]      insert;
  hvs_chain_ctl_t            chain_ctl;

  logic [GRID_WIDTH_W-1:0]   w_eff;
  logic [COL_W-1:0]          w_last;
  logic [ROW_W-1:0]          h_last;
  logic                      in_xfer, flush_step, cand_can_load, cand_go, out_free, out_load;
  logic                      row_end, frame_end, keep, geom_write;
  logic                      bx, by;
  logic [ROW_W-1:0]          dec_row;

  // effective geometry: width clamped between two and the chain, height at least two
  always_comb begin
    if (grid_width_r < GRID_WIDTH_W'(2)) begin
      w_eff = GRID_WIDTH_W'(2);
    end else if ({1'b0, grid_width_r} > (GRID_WIDTH_W + 1)'(MAX_WIDTH)) begin
      w_eff = GRID_WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_r;
    end
  end

  assign w_last = COL_W'(w_eff - GRID_WIDTH_W'(1));
  assign h_last = (grid_height_r < ROW_W'(2)) ? ROW_W'(1) : grid_height_r - ROW_W'(1);

  // handshakes
  assign out_free      = !out_valid_r || out_ch.ready;
  assign cand_go       = cand_valid_r && (!keep || out_free);
  assign cand_can_load = !cand_valid_r || cand_go;
  assign in_ch.ready   = cand_can_load && !flush_r;
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign flush_step    = flush_r && cand_can_load;
  assign out_load      = cand_valid_r && keep && out_free;

  assign row_end   = (col_r == w_last);
  assign frame_end = row_end && (row_r == h_last);
  assign geom_write = cfg_we && (cfg_index == CFG_GRID_WIDTH || cfg_index == CFG_GRID_HEIGHT);

  // the cell chain: samples enter at the cell of the last column and move toward cell zero
  assign chain_ctl.shift  = in_xfer;
  assign chain_ctl.rotate = flush_step;
  assign chain_ctl.sample = in_ch.height_sample;
  assign chain_ctl.head   = prior_q[0];

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    assign insert[k] = (w_last == COL_W'(k));
    if (k == MAX_WIDTH - 1) begin : g_end
      hvs_cell u_cell (
        .clk         (clk),
        .ctl         (chain_ctl),
        .insert      (insert[k]),
        .prior_right ('0),
        .older_right ('0),
        .prior_q     (prior_q[k]),
        .older_q     (older_q[k])
      );
    end else begin : g_mid
      hvs_cell u_cell (
        .clk         (clk),
        .ctl         (chain_ctl),
        .insert      (insert[k]),
        .prior_right (prior_q[k+1]),
        .older_right (older_q[k+1]),
        .prior_q     (prior_q[k]),
        .older_q     (older_q[k])
      );
    end
  end

  hvs_decide u_decide (
    .cand      (cand_r),
    .edge_thr  (edge_thr_r),
    .inner_thr (inner_thr_r),
    .keep      (keep)
  );

  // configuration writes
  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    x_origin_nxt    = x_origin_r;
    z_origin_nxt    = z_origin_r;
    y_base_nxt      = y_base_r;
    edge_thr_nxt    = edge_thr_r;
    inner_thr_nxt   = inner_thr_r;
    if (cfg_we) begin
      unique case (hvs_cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width_nxt  = cfg_wdata[GRID_WIDTH_W-1:0];
        CFG_GRID_HEIGHT: grid_height_nxt = cfg_wdata[ROW_W-1:0];
        CFG_X_ORIGIN:    x_origin_nxt    = cfg_wdata[ORIGIN_W-1:0];
        CFG_Z_ORIGIN:    z_origin_nxt    = cfg_wdata[ORIGIN_W-1:0];
        CFG_Y_BASE:      y_base_nxt      = cfg_wdata[YBASE_W-1:0];
        CFG_EDGE_THR:    edge_thr_nxt    = cfg_wdata[EDGE_THR_W-1:0];
        CFG_INNER_THR:   inner_thr_nxt   = cfg_wdata[INNER_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position and last-row flush
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    flush_nxt  = flush_r;
    fl_col_nxt = fl_col_r;
    lf_nxt     = lf_r;
    if (in_xfer || flush_step) begin
      // left neighbour of the next point is the sample that leaves the chain now
      lf_nxt = prior_q[0];
    end
    if (geom_write) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_xfer) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    if (in_xfer && frame_end) begin
      flush_nxt  = 1'b1;
      fl_col_nxt = '0;
    end else if (flush_step) begin
      fl_col_nxt = fl_col_r + COL_W'(1);
      if (fl_col_r == w_last) begin
        flush_nxt = 1'b0;
      end
    end
  end

  // candidate stage: a point of the previous row, or a last-row point during flush
  assign dec_row = row_r - ROW_W'(1);
  assign bx = (col_r == '0) || row_end;
  assign by = (dec_row == '0) || (dec_row == h_last);

  always_comb begin
    cand_nxt       = cand_r;
    cand_col_nxt   = cand_col_r;
    cand_row_nxt   = cand_row_r;
    cand_valid_nxt = cand_go ? 1'b0 : cand_valid_r;
    if (in_xfer && row_r != '0) begin
      cand_valid_nxt = 1'b1;
      if (bx && by) begin
        cand_nxt.mode = MODE_CORNER;
      end else if (bx) begin
        cand_nxt.mode = MODE_VEDGE;
      end else if (by) begin
        cand_nxt.mode = MODE_HEDGE;
      end else begin
        cand_nxt.mode = MODE_INNER;
      end
      cand_nxt.ct   = prior_q[0];
      cand_nxt.lf   = lf_r;
      cand_nxt.rt   = prior_q[1];
      cand_nxt.up   = older_q[0];
      cand_nxt.dn   = in_ch.height_sample;
      // the flush that follows the final sample delivers the last vertex of that transfer
      cand_nxt.last = !frame_end;
      cand_col_nxt  = col_r;
      cand_row_nxt  = dec_row;
    end else if (flush_step) begin
      cand_valid_nxt = 1'b1;
      cand_nxt.mode  = (fl_col_r == '0 || fl_col_r == w_last) ? MODE_CORNER : MODE_HEDGE;
      cand_nxt.ct    = prior_q[0];
      cand_nxt.lf    = lf_r;
      cand_nxt.rt    = prior_q[1];
      cand_nxt.up    = '0;
      cand_nxt.dn    = '0;
      cand_nxt.last  = (fl_col_r == w_last);
      cand_col_nxt   = fl_col_r;
      cand_row_nxt   = h_last;
    end
  end

  // output register: world coordinates wrap to the field widths
  always_comb begin
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = VX_W'($signed({1'b0, cand_col_r})) + VX_W'($signed(x_origin_r));
      out_y_nxt     = VY_W'($signed({1'b0, cand_r.ct})) + VY_W'($signed(y_base_r));
      out_z_nxt     = VZ_W'($signed({1'b0, cand_row_r})) + VZ_W'($signed(z_origin_r));
      out_col_nxt   = COLUMN_W'(cand_col_r);
      out_row_nxt   = cand_row_r;
      out_last_nxt  = cand_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RST_GRID_WIDTH;
      grid_height_r <= RST_GRID_HEIGHT;
      x_origin_r    <= '0;
      z_origin_r    <= '0;
      y_base_r      <= RST_Y_BASE;
      edge_thr_r    <= '0;
      inner_thr_r   <= RST_INNER_THR;
      col_r         <= '0;
      row_r         <= '0;
      flush_r       <= 1'b0;
      fl_col_r      <= '0;
      cand_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      x_origin_r    <= x_origin_nxt;
      z_origin_r    <= z_origin_nxt;
      y_base_r      <= y_base_nxt;
      edge_thr_r    <= edge_thr_nxt;
      inner_thr_r   <= inner_thr_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      flush_r       <= flush_nxt;
      fl_col_r      <= fl_col_nxt;
      cand_valid_r  <= cand_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lf_r       <= lf_nxt;
    cand_r     <= cand_nxt;
    cand_col_r <= cand_col_nxt;
    cand_row_r <= cand_row_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.vertex_x          = out_x_r;
  assign out_ch.vertex_y_quarters = out_y_r;
  assign out_ch.vertex_z          = out_z_r;
  assign out_ch.column            = out_col_r;
  assign out_ch.row               = out_row_r;
  assign out_ch.last_of_run       = out_last_r;

endmodule

`default_nettype wire

>>> sim/heightmap_vertex_selector_top_tb.sv
// self-checking testbench of the heightmap vertex selector, directed table then random frames
`timescale 1ns / 1ps

module heightmap_vertex_selector_top_tb;
  import hvs_pkg::*;

  // one kept grid point as it leaves on the result channel
  typedef struct packed {
    logic signed [VX_W-1:0]  x;
    logic signed [VY_W-1:0]  y;
    logic signed [VZ_W-1:0]  z;
    logic [COLUMN_W-1:0]     column;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } vertex_t;

  // one row of the directed table: a register write or a sample transfer
  typedef struct packed {
    logic                  is_cfg;
    hvs_cfg_idx_t          idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   sample;
    logic                  typed;    // expected vertices are read from the typed list
    logic [1:0]            n_typed;
  } stim_row_t;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_WIDTH + 16;  // flush of a full row plus pipeline
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIRECTED_ROWS = 41;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hvs_in_if  in_ch ();
  hvs_out_if out_ch ();

  heightmap_vertex_selector_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: register copies, row stores and raster position
  // ---------------------------------------------------------------------------
  logic [GRID_WIDTH_W-1:0]       width_reg     = RST_GRID_WIDTH;
  logic [ROW_W-1:0]              height_reg    = RST_GRID_HEIGHT;
  logic signed [ORIGIN_W-1:0]    x_org_reg     = '0;
  logic signed [ORIGIN_W-1:0]    z_org_reg     = '0;
  logic signed [YBASE_W-1:0]     ybase_reg     = RST_Y_BASE;
  logic [EDGE_THR_W-1:0]         edge_thr_reg  = '0;
  logic [INNER_THR_W-1:0]        inner_thr_reg = RST_INNER_THR;
  logic [SAMPLE_W-1:0]           prior_row_q [DEF_MAX_WIDTH];
  logic [SAMPLE_W-1:0]           older_row_q [DEF_MAX_WIDTH];
  int                            col_pos = 0;
  int                            row_pos = 0;

  vertex_t step_results [$];   // vertices caused by the latest sample
  vertex_t vertex_queue [$];   // vertices still owed by the block, oldest first

  int gap_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int vertices_checked = 0;
  int samples_fed = 0;
  int frames_started = 0;
  int cycle_count = 0;
  bit fed_since_settle = 1'b0;

  hvs_cfg_idx_t side_regs [5] = '{CFG_X_ORIGIN, CFG_Z_ORIGIN, CFG_Y_BASE,
                                  CFG_EDGE_THR, CFG_INNER_THR};

  // directed stimulus: reset values, coordinate extremes, clamped geometry,
  // thresholds right on the keep boundary, a frame cut short by a geometry write
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // 2x2 frame with reset origins and base: every point is a corner
    '{1'b1, CFG_GRID_WIDTH,  18'd2, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_GRID_HEIGHT, 18'd2, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h00, 1'b1, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b1, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hA5, 1'b1, 2'd1},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h5A, 1'b1, 2'd3},
    // most negative x and base, most positive z, width and height below the minimum
    '{1'b1, CFG_X_ORIGIN,    18'h04000, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_Z_ORIGIN,    18'h03FFF, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_Y_BASE,      18'h20000, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_GRID_WIDTH,  18'd1, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_GRID_HEIGHT, 18'd0, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b1, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h00, 1'b1, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h00, 1'b1, 2'd1},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b1, 2'd3},
    // 3x3 checkerboard with thresholds at the largest sums: sums land exactly on the limits
    '{1'b1, CFG_Y_BASE,      18'h1FFFF, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_X_ORIGIN,    18'h03FFF, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_Z_ORIGIN,    18'h04000, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_EDGE_THR,    18'd510, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_INNER_THR,   18'd1020, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_GRID_WIDTH,  18'd3, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_GRID_HEIGHT, 18'd3, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hFF, 1'b0, 2'd0},
    // tallest height, one row only, then a geometry write cuts the frame short
    '{1'b1, CFG_GRID_HEIGHT, 18'd4095, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h12, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'hED, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h80, 1'b0, 2'd0},
    '{1'b1, CFG_GRID_WIDTH,  18'd2, 8'h00, 1'b0, 2'd0},
    '{1'b1, CFG_GRID_HEIGHT, 18'd2, 8'h00, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h01, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h02, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h40, 1'b0, 2'd0},
    '{1'b0, CFG_GRID_WIDTH,  18'd0, 8'h80, 1'b0, 2'd0}
  };

  // vertices of the two corner-only frames, read straight off the coordinates
  vertex_t typed_vertices [8] = '{
    '{16'sd0,      19'sd4,       16'sd0,     5'd0, 12'd0, 1'b1},
    '{16'sd1,      19'sd259,     16'sd0,     5'd1, 12'd0, 1'b0},
    '{16'sd0,      19'sd169,     16'sd1,     5'd0, 12'd1, 1'b0},
    '{16'sd1,      19'sd94,      16'sd1,     5'd1, 12'd1, 1'b1},
    '{-16'sd16384, -19'sd130817, 16'sd16383, 5'd0, 12'd0, 1'b1},
    '{-16'sd16383, -19'sd131072, 16'sd16383, 5'd1, 12'd0, 1'b0},
    '{-16'sd16384, -19'sd131072, 16'sd16384, 5'd0, 12'd1, 1'b0},
    '{-16'sd16383, -19'sd130817, 16'sd16384, 5'd1, 12'd1, 1'b1}
  };

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg < 2) ? 2 : int'(height_reg);
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // corners always stay, border points test along the border, interior points curvature
  function automatic bit keeps_point(input int r, input int c, input int w, input int h,
                                     input int lf, input int ct, input int rt,
                                     input int up, input int dn);
    bit on_col_edge;
    bit on_row_edge;
    on_col_edge = (c == 0) || (c == w - 1);
    on_row_edge = (r == 0) || (r == h - 1);
    if (on_col_edge && on_row_edge) return 1'b1;
    if (on_col_edge) return magnitude(up - ct) + magnitude(dn - ct) > int'(edge_thr_reg);
    if (on_row_edge) return magnitude(lf - ct) + magnitude(rt - ct) > int'(edge_thr_reg);
    return magnitude(up + dn - 2 * ct) + magnitude(lf + rt - 2 * ct) > int'(inner_thr_reg);
  endfunction

  function automatic vertex_t make_vertex(input int r, input int c, input int s);
    vertex_t v;
    v.x      = VX_W'(c + int'(x_org_reg));
    v.y      = VY_W'(s + int'(ybase_reg));
    v.z      = VZ_W'(r + int'(z_org_reg));
    v.column = COLUMN_W'(c);
    v.row    = ROW_W'(r);
    v.last   = 1'b0;
    return v;
  endfunction

  // a point of row r is settled by the sample below it; the frame's last sample flushes
  // the whole bottom row
  function automatic void predict_step(input logic [SAMPLE_W-1:0] s);
    int w, h, c, r, rr, k, ct, lf, rt, up;
    vertex_t v;
    w = eff_width();
    h = eff_height();
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    step_results.delete();
    if (r >= 1) begin
      rr = r - 1;
      ct = int'(prior_row_q[c]);
      lf = (c > 0) ? int'(older_row_q[c-1]) : 0;
      rt = (c + 1 < w) ? int'(prior_row_q[c+1]) : 0;
      up = (rr >= 1) ? int'(older_row_q[c]) : 0;
      if (keeps_point(rr, c, w, h, lf, ct, rt, up, int'(s)))
        step_results.push_back(make_vertex(rr, c, ct));
    end
    older_row_q[c] = prior_row_q[c];
    prior_row_q[c] = s;
    c++;
    if (c == w) begin
      c = 0;
      r++;
      if (r == h) begin
        for (k = 0; k < w; k++) begin
          ct = int'(prior_row_q[k]);
          lf = (k > 0) ? int'(prior_row_q[k-1]) : 0;
          rt = (k + 1 < w) ? int'(prior_row_q[k+1]) : 0;
          if (keeps_point(h - 1, k, w, h, lf, ct, rt, 0, 0))
            step_results.push_back(make_vertex(h - 1, k, ct));
        end
        r = 0;
      end
    end
    col_pos = c;
    row_pos = r;
    if (step_results.size() > 0) begin
      v = step_results.pop_back();
      v.last = 1'b1;
      step_results.push_back(v);
    end
  endfunction

  // random register content, weighted towards the extremes and the interesting range
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input hvs_cfg_idx_t idx);
    int pick;
    pick = $urandom_range(0, 9);
    case (idx)
      CFG_GRID_WIDTH: begin
        if (pick == 0) return CFG_DATA_W'($urandom_range(0, 1));
        if (pick == 1) return CFG_DATA_W'(32);
        if (pick == 2) return CFG_DATA_W'($urandom_range(33, 63));
        return CFG_DATA_W'($urandom_range(2, 6));
      end
      CFG_X_ORIGIN, CFG_Z_ORIGIN: begin
        if (pick == 0) return 18'h04000;
        if (pick == 1) return 18'h03FFF;
        return CFG_DATA_W'($urandom);
      end
      CFG_Y_BASE: begin
        if (pick == 0) return 18'h20000;
        if (pick == 1) return 18'h1FFFF;
        return CFG_DATA_W'($urandom);
      end
      CFG_EDGE_THR: begin
        if (pick == 0) return CFG_DATA_W'(0);
        if (pick == 1) return CFG_DATA_W'(510);
        if (pick == 2) return CFG_DATA_W'(511);
        return CFG_DATA_W'($urandom_range(0, 48));
      end
      CFG_INNER_THR: begin
        if (pick == 0) return CFG_DATA_W'(0);
        if (pick == 1) return CFG_DATA_W'(1020);
        if (pick == 2) return CFG_DATA_W'(1023);
        return CFG_DATA_W'($urandom_range(0, 96));
      end
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // the port takes the write at the edge; geometry writes restart the raster
  task automatic write_reg(input hvs_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_GRID_WIDTH: begin
        width_reg = data[GRID_WIDTH_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      CFG_GRID_HEIGHT: begin
        height_reg = data[ROW_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      CFG_X_ORIGIN:  x_org_reg     = data[ORIGIN_W-1:0];
      CFG_Z_ORIGIN:  z_org_reg     = data[ORIGIN_W-1:0];
      CFG_Y_BASE:    ybase_reg     = data[YBASE_W-1:0];
      CFG_EDGE_THR:  edge_thr_reg  = data[EDGE_THR_W-1:0];
      CFG_INNER_THR: inner_thr_reg = data[INNER_THR_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // returns at the edge of the transfer, leaving valid high for a back-to-back sample
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.height_sample <= value;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    fed_since_settle = 1'b1;
    samples_fed++;
  endtask

  task automatic feed_sample(input logic [SAMPLE_W-1:0] value);
    send_sample(value);
    predict_step(value);
    foreach (step_results[j]) vertex_queue.push_back(step_results[j]);
  endtask

  // idle the block: every owed vertex out, then time for a flush that yields nothing
  task automatic settle_block();
    if (!fed_since_settle) return;
    in_ch.valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fed_since_settle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase, k, n, total, style, base, phase_items, typed_next;
    logic [CFG_DATA_W-1:0] hval;
    logic [SAMPLE_W-1:0] value;
    int gap_plan [4];
    int stall_plan [4];

    // phases: no idling, sender idle, receiver stalling, both
    gap_plan   = '{0, 62, 0, 37};
    stall_plan = '{0, 0, 62, 37};

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_GRID_WIDTH;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.height_sample <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling on either side
    typed_next = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_block();
        if (directed_rows[i].idx == CFG_GRID_WIDTH) frames_started++;
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else if (directed_rows[i].typed) begin
        send_sample(directed_rows[i].sample);
        predict_step(directed_rows[i].sample);
        for (k = 0; k < int'(directed_rows[i].n_typed); k++) begin
          vertex_queue.push_back(typed_vertices[typed_next]);
          typed_next++;
        end
      end else begin
        feed_sample(directed_rows[i].sample);
      end
    end

    // random frames, mostly complete, some cut short by the next geometry write
    for (phase = 0; phase < 4; phase++) begin
      settle_block();
      gap_pct   = gap_plan[phase];
      stall_pct = stall_plan[phase];
      phase_items = 0;
      while (phase_items < 30) begin
        settle_block();
        write_reg(CFG_GRID_WIDTH, pick_reg_value(CFG_GRID_WIDTH));
        // wide rows get short frames so the run stays small
        if (eff_width() >= 16)
          hval = CFG_DATA_W'($urandom_range(0, 2));
        else if ($urandom_range(0, 9) == 0)
          hval = CFG_DATA_W'($urandom_range(0, 1));
        else
          hval = CFG_DATA_W'($urandom_range(2, 5));
        write_reg(CFG_GRID_HEIGHT, hval);
        foreach (side_regs[j])
          if ($urandom_range(0, 1) == 1) write_reg(side_regs[j], pick_reg_value(side_regs[j]));
        frames_started++;

        total = eff_width() * eff_height();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 248);
        for (k = 0; k < n; k++) begin
          case (style)
            0: value = SAMPLE_W'($urandom_range(0, 255));
            1: value = SAMPLE_W'(base + $urandom_range(0, 7));     // gentle slope
            2: value = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default: value = ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom_range(0, 255))
                                                         : SAMPLE_W'(base);  // flat, spikes
          endcase
          feed_sample(value);
          phase_items++;
          // now and then retune a non-geometry register in the middle of a frame
          if (k < n - 1 && $urandom_range(0, 29) == 0) begin
            settle_block();
            write_reg(side_regs[$urandom_range(0, 4)],
                      pick_reg_value(side_regs[$urandom_range(0, 4)]));
          end
        end
      end
    end

    settle_block();
    $display("covered %0d samples in %0d frames, %0d vertices compared", samples_fed,
             frames_started, vertices_checked);
    $display("geometry from clamped minimum to full width, four idling mixes");
    if (mismatch_count == 0 && vertex_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver, checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) < stall_pct) ? 1'b0 : 1'b1;
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // every result transfer is matched against the oldest owed vertex
  always @(posedge clk) begin : result_check
    vertex_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (vertex_queue.size() == 0) begin
        $display("%0t: unexpected vertex, expected none, actual col %0d row %0d", $time,
                 out_ch.column, out_ch.row);
        mismatch_count++;
      end else begin
        want = vertex_queue[0];
        vertex_queue.delete(0);
        check_field("vertex_x", 32'(want.x), 32'(out_ch.vertex_x));
        check_field("vertex_y_quarters", 32'(want.y), 32'(out_ch.vertex_y_quarters));
        check_field("vertex_z", 32'(want.z), 32'(out_ch.vertex_z));
        check_field("column", 32'(want.column), 32'(out_ch.column));
        check_field("row", 32'(want.row), 32'(out_ch.row));
        check_field("last_of_run", 32'(want.last), 32'(out_ch.last_of_run));
        vertices_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices still owed", cycle_count,
               vertex_queue.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
